// ===== sv/lfu_pkg.sv =====
// shared types and constants for the lfu cache table
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [CFG_W-1:0]   ACTIVE_RESET = 5'd16;
  localparam logic [VAL_W-1:0]   MISS_VALUE   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic   found;
    logic   best_ok;
    entry_t match;
    entry_t best;
  } sel_res_t;

endpackage

// ===== sv/lfu_ifs.sv =====
// handshake channels for requests, responses and the configuration write
interface lfu_req_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] store_value;

  modport source (output valid, opcode, lookup_key, store_value, input ready);
  modport sink   (input valid, opcode, lookup_key, store_value, output ready);
endinterface

interface lfu_resp_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/lfu_cache_table.sv =====
// lfu cache table: key-value store with lfu replacement and lru tie-break
//
// req carries opcode (get or put), lookup_key and store_value; one transaction
// on req gives exactly one transaction on resp with hit, read_value, evicted
// and evicted_key. cfg writes active_entries (entries in use, zero disables
// puts) and is always ready; write it only while no request is in flight.
// Each request scans the filled slots one per cycle through the entry
// memory's single registered read port and the shared compare unit, then
// does the update write in the decide state once the output register is
// free. The next request is taken only once the block is back in idle, so
// no request is accepted while the previous one is still being processed.
// Valid slots always form the range below the fill count, so the memory needs
// no clearing after reset: reset empties the cache, zeroes the access clock
// and sets active_entries to 16.
// A finished response waits in the output register while resp is stalled; a
// new request may be accepted meanwhile, but its update waits for that
// response to be taken.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  lfu_req_if.sink      req,
  lfu_resp_if.source   resp,
  lfu_cfg_if.sink      cfg
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t             state;
  logic [CFG_W-1:0]   active_entries;
  logic [OCC_W-1:0]   occupancy;
  logic [STAMP_W-1:0] access_clock;
  logic [IDX_W-1:0]   iss_addr;

  logic               op;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   val;

  entry_t             mem [CAPACITY];
  entry_t             rd_ent;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;

  sel_res_t           sel;
  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   best_idx;

  logic               req_fire;
  logic               last_issue;
  logic               resp_free;

  // update decision
  logic               d_hit;
  logic [VAL_W-1:0]   d_value;
  logic               d_evicted;
  logic [KEY_W-1:0]   d_ev_key;
  logic               d_wr;
  logic               d_insert;
  logic [IDX_W-1:0]   d_slot;
  entry_t             d_ent;
  logic               full;
  logic [COUNT_W-1:0] match_count_inc;

  logic               d_out_hit;
  logic signed [VAL_W-1:0] d_out_value;
  logic               d_out_evicted;
  logic signed [KEY_W-1:0] d_out_ev_key;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign cfg.ready  = 1'b1;
  assign last_issue = (32'(iss_addr) == 32'(occupancy) - 32'd1);
  assign resp_free  = !resp.valid || resp.ready;

  assign resp.hit         = d_out_hit;
  assign resp.read_value  = d_out_value;
  assign resp.evicted     = d_out_evicted;
  assign resp.evicted_key = d_out_ev_key;

  lfu_sel #(.IDX_W(IDX_W)) u_sel (
    .clk        (clk),
    .rst        (rst),
    .clear      (req_fire),
    .cand_valid (rd_pend),
    .cand_idx   (rd_idx),
    .cand       (rd_ent),
    .key        (key),
    .res        (sel),
    .match_idx  (match_idx),
    .best_idx   (best_idx)
  );

  // entry memory: one registered read port for the scan, one write port
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      rd_ent <= mem[iss_addr];
    end
    rd_idx <= iss_addr;
    if (d_wr && state == S_DECIDE && resp_free) begin
      mem[d_slot] <= d_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
    end
  end

  // limit = min(active_entries, CAPACITY)
  assign full = (32'(occupancy) >= 32'(active_entries)) || (32'(occupancy) >= CAPACITY);
  assign match_count_inc = (sel.match.count == COUNT_MAX) ? COUNT_MAX
                                                          : sel.match.count + 1'b1;

  always_comb begin
    d_hit     = 1'b0;
    d_value   = '0;
    d_evicted = 1'b0;
    d_ev_key  = '0;
    d_wr      = 1'b0;
    d_insert  = 1'b0;
    d_slot    = match_idx;
    d_ent.key   = key;
    d_ent.value = sel.match.value;
    d_ent.count = match_count_inc;
    d_ent.stamp = access_clock;
    if (op == OP_GET) begin
      if (sel.found) begin
        d_hit   = 1'b1;
        d_value = sel.match.value;
        d_wr    = 1'b1;
      end else begin
        d_value = MISS_VALUE;
      end
    end else if (active_entries != '0) begin
      d_wr        = 1'b1;
      d_ent.value = val;
      if (sel.found) begin
        d_hit = 1'b1;
      end else begin
        d_ent.count = COUNT_W'(1);
        if (full) begin
          d_evicted = 1'b1;
          d_ev_key  = sel.best.key;
          d_slot    = best_idx;
        end else begin
          // slots fill from the bottom, so the first free slot is the fill count
          d_insert = 1'b1;
          d_slot   = occupancy[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active_entries <= ACTIVE_RESET;
      occupancy      <= '0;
      access_clock   <= '0;
      resp.valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        active_entries <= cfg.data;
      end
      // in decide the output register is reloaded whenever it is free
      if (resp.valid && resp.ready && state != S_DECIDE) begin
        resp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            op       <= req.opcode;
            key      <= req.lookup_key;
            val      <= req.store_value;
            iss_addr <= '0;
            state    <= (occupancy == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_issue) begin
            state <= S_DRAIN;
          end else begin
            iss_addr <= iss_addr + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (resp_free) begin
            resp.valid    <= 1'b1;
            d_out_hit     <= d_hit;
            d_out_value   <= d_value;
            d_out_evicted <= d_evicted;
            d_out_ev_key  <= d_ev_key;
            if (d_wr) begin
              access_clock <= access_clock + 1'b1;
            end
            if (d_insert) begin
              occupancy <= occupancy + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/lfu_sel.sv =====
// shared compare unit: tracks the key match and the lfu victim over a scan
module lfu_sel import lfu_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  cand_valid,
  input  logic [IDX_W-1:0]      cand_idx,
  input  entry_t                cand,
  input  logic [KEY_W-1:0]      key,
  output sel_res_t              res,
  output logic [IDX_W-1:0]      match_idx,
  output logic [IDX_W-1:0]      best_idx
);

  logic key_eq;
  logic older;

  assign key_eq = (cand.key == key);
  // lower count wins, then the smaller stamp
  assign older  = (cand.count < res.best.count) ||
                  ((cand.count == res.best.count) && (cand.stamp < res.best.stamp));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.found   <= 1'b0;
      res.best_ok <= 1'b0;
    end else if (cand_valid) begin
      if (!res.found && key_eq) begin
        res.found <= 1'b1;
        res.match <= cand;
        match_idx <= cand_idx;
      end
      if (!res.best_ok || older) begin
        res.best_ok <= 1'b1;
        res.best    <= cand;
        best_idx    <= cand_idx;
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for lfu_cache_table with a built-in cache predictor
`timescale 1ns / 1ps

module tb import lfu_pkg::*; ();

  localparam int SLOTS      = 16;
  localparam int STALL_STOP = 3000;
  localparam int DRAIN_WAIT = 40;
  localparam int PHASE_LEN  = 100;
  localparam int NUM_PHASES = 16;
  localparam int POOL_SIZE  = 24;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_reply_t;

  logic clk;
  logic rst;

  lfu_req_if  req_bus ();
  lfu_resp_if resp_bus ();
  lfu_cfg_if  cfg_bus ();

  lfu_cache_table #(.CAPACITY(SLOTS)) DUT (
    .clk  (clk),
    .rst  (rst),
    .req  (req_bus),
    .resp (resp_bus),
    .cfg  (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted cache contents
  logic               slot_used  [SLOTS];
  logic [KEY_W-1:0]   slot_key   [SLOTS];
  logic [VAL_W-1:0]   slot_val   [SLOTS];
  logic [COUNT_W-1:0] slot_uses  [SLOTS];
  logic [STAMP_W-1:0] slot_stamp [SLOTS];
  logic [STAMP_W-1:0] touch_clock;
  int                 fill_count;
  logic [CFG_W-1:0]   limit_reg;

  cache_req_t   request_backlog[$];
  cache_reply_t replies_due[$];
  int           fault_count;
  int           send_idle_pct;
  int           stall_pct;
  int           quiet_cycles;

  function automatic void touch_slot(int s);
    if (slot_uses[s] != COUNT_MAX) slot_uses[s] = slot_uses[s] + 1'b1;
    slot_stamp[s] = touch_clock;
    touch_clock   = touch_clock + 1'b1;
  endfunction

  function automatic cache_reply_t apply_request(cache_req_t r);
    cache_reply_t o;
    int           match_slot;
    int           dst;
    int           eff;
    o          = '0;
    match_slot = -1;
    dst        = -1;
    eff        = (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
    for (int i = 0; i < SLOTS; i++) begin
      if (match_slot < 0 && slot_used[i] && slot_key[i] == r.key) match_slot = i;
    end
    if (r.opcode == OP_GET) begin
      if (match_slot < 0) begin
        o.read_value = MISS_VALUE;
      end else begin
        o.hit        = 1'b1;
        o.read_value = slot_val[match_slot];
        touch_slot(match_slot);
      end
    end else if (eff != 0) begin
      if (match_slot >= 0) begin
        o.hit                = 1'b1;
        slot_val[match_slot] = r.value;
        touch_slot(match_slot);
      end else begin
        if (fill_count >= eff) begin
          // lowest use count, oldest stamp on ties, lowest slot on full ties
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && (dst < 0 || slot_uses[i] < slot_uses[dst] ||
                (slot_uses[i] == slot_uses[dst] && slot_stamp[i] < slot_stamp[dst])))
              dst = i;
          end
          o.evicted     = 1'b1;
          o.evicted_key = slot_key[dst];
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_used[i]) dst = i;
          end
          fill_count++;
        end
        slot_used[dst]  = 1'b1;
        slot_key[dst]   = r.key;
        slot_val[dst]   = r.value;
        slot_uses[dst]  = COUNT_W'(1);
        slot_stamp[dst] = touch_clock;
        touch_clock     = touch_clock + 1'b1;
      end
    end
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        replies_due.push_back(apply_request(request_backlog[0]));
        void'(request_backlog.pop_front());
      end
      if (!(req_bus.valid && !req_bus.ready)) begin
        if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_bus.valid       <= 1'b1;
          req_bus.opcode      <= request_backlog[0].opcode;
          req_bus.lookup_key  <= request_backlog[0].key;
          req_bus.store_value <= request_backlog[0].value;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_fault(string what, cache_reply_t want, cache_reply_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("mismatch (%s) at %0t: want hit %0b val %h ev %0b key %h",
               what, $realtime, want.hit, want.read_value, want.evicted, want.evicted_key);
      $display("  got hit %0b val %h ev %0b key %h",
               got.hit, got.read_value, got.evicted, got.evicted_key);
    end
  endtask

  // response monitor
  always @(posedge clk) begin
    cache_reply_t got;
    cache_reply_t want;
    if (rst) begin
      resp_bus.ready <= 1'b0;
    end else begin
      if (resp_bus.valid && resp_bus.ready) begin
        got = '{resp_bus.hit, resp_bus.read_value, resp_bus.evicted, resp_bus.evicted_key};
        if (replies_due.size() == 0) begin
          note_fault("no transaction outstanding", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
            note_fault("field", want, got);
        end
      end
      resp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (resp_bus.valid && resp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_STOP) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic add_req(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    request_backlog.push_back('{op, key, value});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (request_backlog.size() != 0 || replies_due.size() != 0);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    cfg_bus.data  <= v;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    limit_reg = v;
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    logic [CFG_W-1:0] phase_limits[NUM_PHASES];
    logic [KEY_W-1:0] k;
    int               span;
    int               eff;

    clk                  = 1'b0;
    rst                  = 1'b1;
    req_bus.valid        = 1'b0;
    req_bus.opcode       = OP_GET;
    req_bus.lookup_key   = '0;
    req_bus.store_value  = '0;
    resp_bus.ready       = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    fault_count          = 0;
    quiet_cycles         = 0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    touch_clock          = '0;
    fill_count           = 0;
    limit_reg            = ACTIVE_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_val[i]   = '0;
      slot_uses[i]  = '0;
      slot_stamp[i] = '0;
    end
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    phase_limits = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd16, 5'd3, 5'd12,
                     5'd2, 5'd17, 5'd8, 5'd0, 5'd31, 5'd4, 5'd1, 5'd16};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, hits, misses and overwrite at the reset limit
    add_req(OP_GET, KEY_MIN, 32'h0);
    add_req(OP_PUT, KEY_MIN, 32'h7fff_ffff);
    add_req(OP_PUT, KEY_MAX, 32'h8000_0000);
    add_req(OP_PUT, 32'h0, 32'hffff_ffff);
    add_req(OP_PUT, 32'hffff_ffff, 32'h0);
    add_req(OP_GET, KEY_MAX, 32'hffff_ffff);
    add_req(OP_GET, 32'h0, 32'h0);
    add_req(OP_PUT, KEY_MIN, 32'h5);
    add_req(OP_GET, 32'd12345, 32'h0);
    drain();
    // limit below occupancy: every new key evicts
    write_limit(5'd2);
    add_req(OP_PUT, 32'd100, 32'd1);
    add_req(OP_PUT, 32'd101, 32'd2);
    add_req(OP_GET, KEY_MIN, 32'h0);
    add_req(OP_PUT, 32'd102, 32'd3);
    drain();
    // zero limit: puts ignored even on a present key, gets still answer
    write_limit(5'd0);
    add_req(OP_PUT, KEY_MIN, 32'd9);
    add_req(OP_PUT, 32'd200, 32'd9);
    add_req(OP_GET, KEY_MIN, 32'h0);
    add_req(OP_GET, 32'd200, 32'h0);
    drain();
    // register above capacity: new keys fill free slots without eviction
    write_limit(5'd31);
    for (int i = 0; i < 7; i++) add_req(OP_PUT, 32'd300 + i, $urandom);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limits[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      eff  = (phase_limits[p] > SLOTS) ? SLOTS : int'(phase_limits[p]);
      // a key range a little wider than the limit keeps both hits and evictions common
      span = (eff + 4 < POOL_SIZE) ? eff + 4 : POOL_SIZE - 1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, span)];
        add_req($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom);
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0 && replies_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
